// File: rtl/core/gecv_pkg.sv
// Package for the graph edge consensus vote block: types, codes and defaults.
// No dependencies; used by graph_edge_consensus_vote_top.
package gecv_pkg;

    localparam int NODES_DEF      = 64;
    localparam int COUNT_BITS_DEF = 16;

    // Node fields are 6 bits wide; node numbers are compared against NODES at 9 bits.
    localparam int NODE_W     = 6;
    localparam int NODE_CMP_W = 9;

    typedef enum logic [1:0] {
        KIND_ARC   = 2'd0,
        KIND_END   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CHOICE_NONE  = 2'd0,
        CHOICE_FWD   = 2'd1,
        CHOICE_REV   = 2'd2,
        CHOICE_UNDIR = 2'd3
    } t_choice;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_EVAL
    } t_state;

endpackage

// File: rtl/core/graph_edge_consensus_vote_top.sv
// Top level of the graph edge consensus vote block: counter memories, control, result register.
// Depends on gecv_pkg.
//
// Counts arc votes per ordered node pair over a stream of graphs and answers pair queries
// with the edge state that disagrees with the fewest graphs. After reset the block runs a
// clearing pass over all NODES*NODES addresses (4096 at the default size) of both counter
// memories and accepts no request meanwhile. An end-of-graph request and an ignored kind are
// handled in the idle state. An arc reads its counter from memory (registered read) and then
// writes the incremented value back. A query goes through memory read, sum of the counts,
// then compare; its result is held in an output register so the next request is accepted
// while the result waits, and a query stalls in its compare step only while that register is
// still occupied.
module graph_edge_consensus_vote_top #(
    parameter int NODES      = gecv_pkg::NODES_DEF,
    parameter int COUNT_BITS = gecv_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_kind,
    input  logic [gecv_pkg::NODE_W-1:0] i_node_from,
    input  logic [gecv_pkg::NODE_W-1:0] i_node_to,
    input  logic                        i_reverse_present,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_edge_choice,
    output logic [gecv_pkg::NODE_W-1:0] o_pair_low,
    output logic [gecv_pkg::NODE_W-1:0] o_pair_high
);

    localparam int DEPTH  = NODES * NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = COUNT_BITS + 3;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    function automatic logic [ADDR_W-1:0] pair_addr(
        input logic [gecv_pkg::NODE_W-1:0] row,
        input logic [gecv_pkg::NODE_W-1:0] col
    );
        return ADDR_W'(row) * ADDR_W'(NODES) + ADDR_W'(col);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] val);
        return (val == '1) ? val : val + COUNT_BITS'(1);
    endfunction

    // Counter memories
    logic [COUNT_BITS-1:0] mem_dir [DEPTH];
    logic [COUNT_BITS-1:0] mem_und [DEPTH];

    gecv_pkg::t_state r_state, n_state;

    logic [ADDR_W-1:0]           r_clr_addr;
    logic [COUNT_BITS-1:0]       r_graph_total;
    logic [COUNT_BITS-1:0]       r_dir_q0, r_dir_q1, r_und_q;
    logic [ADDR_W-1:0]           r_wr_addr;
    logic                        r_is_query;
    logic                        r_node_ok;
    logic                        r_rev;
    logic [gecv_pkg::NODE_W-1:0] r_lo, r_hi;
    logic signed [SUM_W-1:0]     r_cnt_same, r_cnt_rev, r_cnt_und, r_cnt_none;
    logic                        r_out_valid;
    logic [1:0]                  r_edge_choice;
    logic [gecv_pkg::NODE_W-1:0] r_pair_low, r_pair_high;

    logic                        accept;
    logic                        out_free;
    logic                        load_out;
    logic [gecv_pkg::NODE_W-1:0] in_lo, in_hi;
    logic                        in_arc_ok;
    logic [ADDR_W-1:0]           rd_addr0, rd_addr1;
    logic                        wr_dir, wr_und;
    logic [ADDR_W-1:0]           wr_addr;
    logic [COUNT_BITS-1:0]       wr_dir_data, wr_und_data;
    logic signed [SUM_W-1:0]     sum_same, sum_rev, sum_und, sum_total;
    logic [1:0]                  choice;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign in_lo = (i_node_from < i_node_to) ? i_node_from : i_node_to;
    assign in_hi = (i_node_from < i_node_to) ? i_node_to : i_node_from;
    assign in_arc_ok = (gecv_pkg::NODE_CMP_W'(i_node_from) < gecv_pkg::NODE_CMP_W'(NODES))
                    && (gecv_pkg::NODE_CMP_W'(i_node_to) < gecv_pkg::NODE_CMP_W'(NODES));

    // Arc reads its own pair on both ports; a query reads (lo,hi) and (hi,lo)
    always_comb begin
        if (i_kind == gecv_pkg::KIND_QUERY) begin
            rd_addr0 = pair_addr(in_lo, in_hi);
            rd_addr1 = pair_addr(in_hi, in_lo);
        end else begin
            rd_addr0 = pair_addr(i_node_from, i_node_to);
            rd_addr1 = rd_addr0;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gecv_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        load_out = 1'b0;
        wr_dir   = 1'b0;
        wr_und   = 1'b0;
        wr_addr  = r_wr_addr;
        wr_dir_data = sat_inc(r_dir_q0);
        wr_und_data = sat_inc(r_und_q);
        case (r_state)
            gecv_pkg::ST_CLEAR: begin
                wr_dir      = 1'b1;
                wr_und      = 1'b1;
                wr_addr     = r_clr_addr;
                wr_dir_data = '0;
                wr_und_data = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = gecv_pkg::ST_IDLE;
                end
            end
            gecv_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_kind == gecv_pkg::KIND_ARC || i_kind == gecv_pkg::KIND_QUERY)) begin
                    n_state = gecv_pkg::ST_ACCESS;
                end
            end
            gecv_pkg::ST_ACCESS: begin
                if (r_is_query) begin
                    n_state = gecv_pkg::ST_EVAL;
                end else begin
                    wr_dir  = r_node_ok && !r_rev;
                    wr_und  = r_node_ok && r_rev;
                    n_state = gecv_pkg::ST_IDLE;
                end
            end
            gecv_pkg::ST_EVAL: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = gecv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gecv_pkg::ST_IDLE;
            end
        endcase
    end

    // Memories: one write port each, registered reads
    always_ff @(posedge i_clk) begin
        if (wr_dir) begin
            mem_dir[wr_addr] <= wr_dir_data;
        end
        if (accept) begin
            r_dir_q0 <= mem_dir[rd_addr0];
            r_dir_q1 <= mem_dir[rd_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_und) begin
            mem_und[wr_addr] <= wr_und_data;
        end
        if (accept) begin
            r_und_q <= mem_und[rd_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_graph_total <= '0;
        end else begin
            if (r_state == gecv_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (accept && i_kind == gecv_pkg::KIND_END) begin
                r_graph_total <= sat_inc(r_graph_total);
            end
        end
    end

    // Request fields held for the access and compare steps
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_query <= (i_kind == gecv_pkg::KIND_QUERY);
            r_rev      <= i_reverse_present;
            r_wr_addr  <= rd_addr0;
            r_lo       <= in_lo;
            r_hi       <= in_hi;
            if (i_kind == gecv_pkg::KIND_QUERY) begin
                r_node_ok <= gecv_pkg::NODE_CMP_W'(in_hi) < gecv_pkg::NODE_CMP_W'(NODES);
            end else begin
                r_node_ok <= in_arc_ok;
            end
        end
    end

    // Count sums; the "none" count may go negative
    assign sum_same  = $signed({3'b000, r_dir_q0});
    assign sum_rev   = $signed({3'b000, r_dir_q1});
    assign sum_und   = $signed({3'b000, r_und_q});
    assign sum_total = $signed({3'b000, r_graph_total});

    always_ff @(posedge i_clk) begin
        if (r_state == gecv_pkg::ST_ACCESS) begin
            r_cnt_same <= sum_same;
            r_cnt_rev  <= sum_rev;
            r_cnt_und  <= sum_und;
            r_cnt_none <= sum_total - sum_same - sum_rev - sum_und;
        end
    end

    // Each cost is the total minus the state's own count, so the fewest
    // disagreements is the largest count; ties keep the earlier state.
    always_comb begin
        choice = gecv_pkg::CHOICE_NONE;
        if (r_node_ok) begin
            if (r_cnt_same > r_cnt_none && r_cnt_same >= r_cnt_rev
                    && r_cnt_same >= r_cnt_und) begin
                choice = gecv_pkg::CHOICE_FWD;
            end else if (r_cnt_rev > r_cnt_none && r_cnt_rev >= r_cnt_und) begin
                choice = gecv_pkg::CHOICE_REV;
            end else if (r_cnt_und > r_cnt_none) begin
                choice = gecv_pkg::CHOICE_UNDIR;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_edge_choice <= choice;
            r_pair_low    <= r_lo;
            r_pair_high   <= r_hi;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_edge_choice = r_edge_choice;
    assign o_pair_low    = r_pair_low;
    assign o_pair_high   = r_pair_high;

    a_out_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == gecv_pkg::ST_EVAL)
        else $error("result loaded outside the compare step");

    a_arc_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gecv_pkg::ST_ACCESS && !r_is_query) |=> r_state == gecv_pkg::ST_IDLE)
        else $error("arc write-back did not return to idle");

    a_clear_full_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gecv_pkg::ST_CLEAR) |=>
            (r_state == gecv_pkg::ST_CLEAR || $past(r_clr_addr) == LAST_ADDR))
        else $error("clearing pass left early");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_graph_total >= $past(r_graph_total))
        else $error("graph total decreased");

endmodule

// File: bench/graph_edge_consensus_vote_top_tb.sv
// Testbench for graph_edge_consensus_vote_top: a directed table, then random graph streams,
// checked result by result against a predictor of the vote counters.
// Depends on gecv_pkg and graph_edge_consensus_vote_top.
module graph_edge_consensus_vote_top_tb;

    localparam int COUNT_W   = gecv_pkg::COUNT_BITS_DEF;
    localparam int PAIR_CNT  = gecv_pkg::NODES_DEF * gecv_pkg::NODES_DEF;
    localparam int NODE_BITS = gecv_pkg::NODE_W;
    // Longest quiet stretch is the clearing pass after reset; allow several times that.
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_ROWS      = 25;

    typedef struct packed {
        gecv_pkg::t_choice    choice;
        logic [NODE_BITS-1:0] low;
        logic [NODE_BITS-1:0] high;
    } t_vote;

    typedef struct packed {
        gecv_pkg::t_kind      kind;
        logic [NODE_BITS-1:0] src;
        logic [NODE_BITS-1:0] dst;
        logic                 rev;
        logic                 typed;
        gecv_pkg::t_choice    choice;
        logic [NODE_BITS-1:0] exp_low;
        logic [NODE_BITS-1:0] exp_high;
    } t_stim_row;

    // Typed answers only where the counts are obvious: right after reset and a single graph.
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{gecv_pkg::KIND_QUERY, 6'd0,  6'd63, 1'b0, 1'b1, gecv_pkg::CHOICE_NONE, 6'd0,  6'd63},
        '{gecv_pkg::KIND_QUERY, 6'd63, 6'd0,  1'b1, 1'b1, gecv_pkg::CHOICE_NONE, 6'd0,  6'd63},
        '{gecv_pkg::KIND_QUERY, 6'd63, 6'd63, 1'b0, 1'b1, gecv_pkg::CHOICE_NONE, 6'd63, 6'd63},
        '{gecv_pkg::KIND_NONE,  6'd63, 6'd63, 1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd0,  6'd63, 1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_END,   6'd0,  6'd0,  1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd0,  6'd63, 1'b0, 1'b1, gecv_pkg::CHOICE_FWD,  6'd0,  6'd63},
        '{gecv_pkg::KIND_QUERY, 6'd63, 6'd0,  1'b0, 1'b1, gecv_pkg::CHOICE_FWD,  6'd0,  6'd63},
        '{gecv_pkg::KIND_ARC,   6'd63, 6'd0,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd63, 6'd0,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_END,   6'd63, 6'd63, 1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_END,   6'd0,  6'd0,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd0,  6'd63, 1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd63, 6'd0,  1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd0,  6'd63, 1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd63, 6'd0,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd5,  6'd5,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd5,  6'd5,  1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd5,  6'd5,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd9,  6'd9,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_ARC,   6'd9,  6'd9,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd9,  6'd9,  1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd1,  6'd2,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_NONE,  6'd0,  6'd0,  1'b0, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0},
        '{gecv_pkg::KIND_QUERY, 6'd62, 6'd63, 1'b1, 1'b0, gecv_pkg::CHOICE_NONE, 6'd0,  6'd0}
    };

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_valid           = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_kind            = gecv_pkg::KIND_NONE;
    logic [NODE_BITS-1:0] i_node_from       = '0;
    logic [NODE_BITS-1:0] i_node_to         = '0;
    logic                 i_reverse_present = 1'b0;
    logic                 o_valid;
    logic                 i_ready           = 1'b0;
    logic [1:0]           o_edge_choice;
    logic [NODE_BITS-1:0] o_pair_low;
    logic [NODE_BITS-1:0] o_pair_high;

    // Predictor state: vote counters per ordered pair and the graph count.
    bit [COUNT_W-1:0] fwd_votes   [PAIR_CNT];
    bit [COUNT_W-1:0] undir_votes [PAIR_CNT];
    bit [COUNT_W-1:0] graph_count;
    t_vote            pending_votes [$];

    int sender_gap_pct  = 0;
    int rcv_stall_pct   = 0;
    int hold_ask        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int mismatches      = 0;
    int votes_checked   = 0;
    int useful_requests = 0;
    int arcs_sent       = 0;
    int ends_sent       = 0;
    int queries_sent    = 0;
    int unused_sent     = 0;

    graph_edge_consensus_vote_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_node_from       (i_node_from),
        .i_node_to         (i_node_to),
        .i_reverse_present (i_reverse_present),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_edge_choice     (o_edge_choice),
        .o_pair_low        (o_pair_low),
        .o_pair_high       (o_pair_high)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (after %0d results)",
                 what, got, want, votes_checked);
        mismatches++;
    endtask

    function automatic void append_vote(input t_vote v);
        pending_votes.insert(pending_votes.size(), v);
    endfunction

    function automatic t_vote vote_for_pair(input logic [NODE_BITS-1:0] a,
                                            input logic [NODE_BITS-1:0] b);
        logic [NODE_BITS-1:0] lo;
        logic [NODE_BITS-1:0] hi;
        longint same, rev, und, total, none_cnt;
        longint c_none, c_fwd, c_rev, c_und;
        t_vote v;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        v.choice = gecv_pkg::CHOICE_NONE;
        v.low    = lo;
        v.high   = hi;
        if (int'(hi) < gecv_pkg::NODES_DEF) begin
            same     = fwd_votes[{lo, hi}];
            rev      = fwd_votes[{hi, lo}];
            und      = undir_votes[{hi, lo}];
            total    = graph_count;
            // the no-edge count may go negative when arcs outnumber ended graphs
            none_cnt = total - same - rev - und;
            c_none   = same + rev + und;
            c_fwd    = rev + und + none_cnt;
            c_rev    = same + und + none_cnt;
            c_und    = same + rev + none_cnt;
            if (c_fwd < c_none && c_fwd <= c_rev && c_fwd <= c_und)
                v.choice = gecv_pkg::CHOICE_FWD;
            else if (c_rev < c_none && c_rev <= c_und)
                v.choice = gecv_pkg::CHOICE_REV;
            else if (c_und < c_none)
                v.choice = gecv_pkg::CHOICE_UNDIR;
        end
        return v;
    endfunction

    task automatic record_request(input gecv_pkg::t_kind kind, input logic [NODE_BITS-1:0] src,
                                  input logic [NODE_BITS-1:0] dst, input logic rev,
                                  input logic typed, input t_vote typed_vote);
        case (kind)
            gecv_pkg::KIND_ARC: begin
                arcs_sent++;
                if (rev) begin
                    if (undir_votes[{src, dst}] != '1) undir_votes[{src, dst}]++;
                end else begin
                    if (fwd_votes[{src, dst}] != '1) fwd_votes[{src, dst}]++;
                end
            end
            gecv_pkg::KIND_END: begin
                ends_sent++;
                if (graph_count != '1) graph_count++;
            end
            gecv_pkg::KIND_QUERY: begin
                queries_sent++;
                if (typed) append_vote(typed_vote);
                else append_vote(vote_for_pair(src, dst));
            end
            default: unused_sent++;
        endcase
        if (kind != gecv_pkg::KIND_NONE) useful_requests++;
    endtask

    task automatic send_request(input gecv_pkg::t_kind kind, input logic [NODE_BITS-1:0] src,
                                input logic [NODE_BITS-1:0] dst, input logic rev,
                                input logic typed, input t_vote typed_vote);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_kind            <= kind;
        i_node_from       <= src;
        i_node_to         <= dst;
        i_reverse_present <= rev;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        record_request(kind, src, dst, rev, typed, typed_vote);
    endtask

    task automatic send_plain(input gecv_pkg::t_kind kind, input logic [NODE_BITS-1:0] src,
                              input logic [NODE_BITS-1:0] dst, input logic rev);
        send_request(kind, src, dst, rev, 1'b0, '0);
    endtask

    // Pause the sender until every pending result has been taken, then let the pipe settle.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_votes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Favor a few nodes, including the top ones, so votes pile up on the same pairs.
    function automatic logic [NODE_BITS-1:0] pick_node();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return NODE_BITS'($urandom_range(0, 3));
        if (r < 8) return NODE_BITS'(60 + $urandom_range(0, 3));
        return NODE_BITS'($urandom_range(0, 63));
    endfunction

    task automatic random_query();
        send_plain(gecv_pkg::KIND_QUERY, pick_node(), pick_node(), 1'($urandom_range(0, 1)));
    endtask

    // One graph: arcs (a flagged reverse arc is also sent half the time), then usually its end marker.
    task automatic random_graph();
        int n_arcs;
        logic [NODE_BITS-1:0] a, b;
        logic rev;
        n_arcs = $urandom_range(1, 6);
        for (int k = 0; k < n_arcs; k++) begin
            a   = pick_node();
            b   = pick_node();
            rev = ($urandom_range(0, 2) == 0);
            send_plain(gecv_pkg::KIND_ARC, a, b, rev);
            if (rev && $urandom_range(0, 1) == 1) send_plain(gecv_pkg::KIND_ARC, b, a, 1'b1);
            if ($urandom_range(0, 9) == 0) random_query();
            if ($urandom_range(0, 19) == 0)
                send_plain(gecv_pkg::KIND_NONE, NODE_BITS'($urandom), NODE_BITS'($urandom),
                           1'($urandom_range(0, 1)));
        end
        // drop the end marker now and then to leave a broken graph behind
        if ($urandom_range(0, 9) != 0)
            send_plain(gecv_pkg::KIND_END, NODE_BITS'($urandom), NODE_BITS'($urandom),
                       1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2)) random_query();
    endtask

    task automatic random_phase(input int n_requests);
        int start;
        start = useful_requests;
        while (useful_requests - start < n_requests) random_graph();
    endtask

    // Receiver: random stalls, a long hold-off on request, and the result check.
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (pending_votes.size() == 0) begin
                report_mismatch("result with nothing pending", o_edge_choice, -1);
            end else begin
                t_vote want;
                want = pending_votes.pop_front();
                if (o_edge_choice != want.choice)
                    report_mismatch("edge_choice", o_edge_choice, want.choice);
                if (o_pair_low != want.low)
                    report_mismatch("pair_low", o_pair_low, want.low);
                if (o_pair_high != want.high)
                    report_mismatch("pair_high", o_pair_high, want.high);
            end
            votes_checked++;
        end
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Watchdog: end the run if no request or result moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        sender_gap_pct = 13;
        rcv_stall_pct <= 60;
        for (int i = 0; i < N_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            send_request(row.kind, row.src, row.dst, row.rev, row.typed,
                         '{row.choice, row.exp_low, row.exp_high});
        end
        random_phase(370);
        wait_for_results();

        // swap: sender idles heavily, receiver lightly
        sender_gap_pct = 60;
        rcv_stall_pct <= 13;
        random_phase(370);
        wait_for_results();

        // no idling; open with a long receiver hold-off while queries keep coming
        sender_gap_pct = 0;
        rcv_stall_pct <= 0;
        hold_ask <= hold_ask + 1;
        repeat (40) random_query();
        random_phase(370);
        wait_for_results();

        send_plain(gecv_pkg::KIND_QUERY, 6'd10, 6'd10, 1'b0);
        send_plain(gecv_pkg::KIND_QUERY, 6'd0, 6'd63, 1'b0);
        random_phase(60);

        i_valid <= 1'b0;
        waited = 0;
        while (pending_votes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        while (pending_votes.size() != 0) begin
            t_vote lost;
            lost = pending_votes.pop_front();
            report_mismatch("result never arrived", -1, lost.choice);
        end

        $display("Run covered %0d arcs, %0d graph ends, %0d queries and %0d unused-kind requests",
                 arcs_sent, ends_sent, queries_sent, unused_sent);
        $display("%0d results checked across three stall mixes and a long receiver hold-off",
                 votes_checked);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gecv_pkg.sv
rtl/core/graph_edge_consensus_vote_top.sv
bench/graph_edge_consensus_vote_top_tb.sv
